>>> sv/gcsl_pkg.sv
`default_nettype none
package gcsl_pkg;

   localparam int unsigned VAL_W   = 18;
   localparam int unsigned TIME_W  = 20;
   localparam int unsigned CFG_W   = 16;
   localparam int unsigned NUM_CFG = 8;

   // Register indexes.
   localparam logic [2:0] REG_LF_FORWARD  = 3'd0;
   localparam logic [2:0] REG_LF_BACKWARD = 3'd1;
   localparam logic [2:0] REG_LF_SIDEWAYS = 3'd2;
   localparam logic [2:0] REG_LF_TURN     = 3'd3;
   localparam logic [2:0] REG_DECEL_RATIO = 3'd4;
   localparam logic [2:0] REG_HF_FORWARD  = 3'd5;
   localparam logic [2:0] REG_HF_SIDEWAYS = 3'd6;
   localparam logic [2:0] REG_HF_TURN     = 3'd7;

   localparam logic [CFG_W-1:0] CFG_RESET = 16'd4096;

   // Datapath operations.
   typedef logic [3:0] op_type;
   localparam op_type OP_NONE     = 4'd0;
   localparam op_type OP_LOAD     = 4'd1;
   localparam op_type OP_LF_MUL1  = 4'd2;
   localparam op_type OP_LF_MUL2  = 4'd3;
   localparam op_type OP_LF_UPD   = 4'd4;
   localparam op_type OP_HF_MUL   = 4'd5;
   localparam op_type OP_HF_UPD   = 4'd6;
   localparam op_type OP_DIV_INIT = 4'd7;
   localparam op_type OP_DIV_STEP = 4'd8;
   localparam op_type OP_EOS_UPD  = 4'd9;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // Quotient bits produced by the divider.
   localparam int unsigned DIV_STEPS = 18;

   typedef struct packed {
      op_type     op;
      logic [1:0] axis;
   } cmd_type;

   typedef struct packed {
      logic scale;
   } status_type;

   typedef struct packed {
      logic [CFG_W-1:0] lf_forward;
      logic [CFG_W-1:0] lf_backward;
      logic [CFG_W-1:0] lf_sideways;
      logic [CFG_W-1:0] lf_turn;
      logic [CFG_W-1:0] decel_ratio;
      logic [CFG_W-1:0] hf_forward;
      logic [CFG_W-1:0] hf_sideways;
      logic [CFG_W-1:0] hf_turn;
   } cfg_type;

endpackage
`default_nettype wire

>>> sv/gcsl_if.sv
`default_nettype none
interface gcsl_req_if;
   logic                valid;
   logic                ready;
   logic signed [17:0]  lf_target_x;
   logic signed [17:0]  lf_target_y;
   logic signed [17:0]  lf_target_z;
   logic signed [17:0]  hf_target_x;
   logic signed [17:0]  hf_target_y;
   logic signed [17:0]  hf_target_z;
   logic signed [17:0]  eos_target_x;
   logic signed [17:0]  eos_target_y;
   logic signed [17:0]  eos_target_z;
   logic        [19:0]  true_dt;
   logic        [19:0]  nominal_dt;
   logic        [19:0]  time_to_step;

   modport source (output valid, lf_target_x, lf_target_y, lf_target_z, hf_target_x,
                   hf_target_y, hf_target_z, eos_target_x, eos_target_y, eos_target_z,
                   true_dt, nominal_dt, time_to_step, input ready);
   modport sink (input valid, lf_target_x, lf_target_y, lf_target_z, hf_target_x,
                 hf_target_y, hf_target_z, eos_target_x, eos_target_y, eos_target_z,
                 true_dt, nominal_dt, time_to_step, output ready);
endinterface

interface gcsl_rsp_if;
   logic                valid;
   logic                ready;
   logic signed [17:0]  lf_x;
   logic signed [17:0]  lf_y;
   logic signed [17:0]  lf_z;
   logic signed [17:0]  hf_x;
   logic signed [17:0]  hf_y;
   logic signed [17:0]  hf_z;
   logic signed [17:0]  eos_x;
   logic signed [17:0]  eos_y;
   logic signed [17:0]  eos_z;

   modport source (output valid, lf_x, lf_y, lf_z, hf_x, hf_y, hf_z, eos_x, eos_y, eos_z,
                   input ready);
   modport sink (input valid, lf_x, lf_y, lf_z, hf_x, hf_y, hf_z, eos_x, eos_y, eos_z,
                 output ready);
endinterface
`default_nettype wire

>>> sv/gcsl_ctrl.sv
`default_nettype none
module gcsl_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire gcsl_pkg::status_type  status,
   output gcsl_pkg::cmd_type          cmd
);
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_LF1  = 4'd1;
   localparam logic [3:0] S_LF2  = 4'd2;
   localparam logic [3:0] S_LF3  = 4'd3;
   localparam logic [3:0] S_HF1  = 4'd4;
   localparam logic [3:0] S_HF2  = 4'd5;
   localparam logic [3:0] S_DIVI = 4'd6;
   localparam logic [3:0] S_DIV  = 4'd7;
   localparam logic [3:0] S_EOS  = 4'd8;
   localparam logic [3:0] S_DONE = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic [4:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         axis_ff  <= gcsl_pkg::AXIS_X;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      axis_in   = axis_ff;
      cnt_in    = cnt_ff;
      cmd.op    = gcsl_pkg::OP_NONE;
      cmd.axis  = axis_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = gcsl_pkg::OP_LOAD;
               axis_in  = gcsl_pkg::AXIS_X;
               state_in = S_LF1;
            end
         end
         S_LF1: begin
            cmd.op   = gcsl_pkg::OP_LF_MUL1;
            state_in = S_LF2;
         end
         S_LF2: begin
            cmd.op   = gcsl_pkg::OP_LF_MUL2;
            state_in = S_LF3;
         end
         S_LF3: begin
            cmd.op = gcsl_pkg::OP_LF_UPD;
            if (axis_ff == gcsl_pkg::AXIS_Z) begin
               axis_in  = gcsl_pkg::AXIS_X;
               state_in = S_HF1;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = S_LF1;
            end
         end
         S_HF1: begin
            cmd.op   = gcsl_pkg::OP_HF_MUL;
            state_in = S_HF2;
         end
         S_HF2: begin
            cmd.op   = gcsl_pkg::OP_HF_UPD;
            state_in = status.scale ? S_DIVI : S_EOS;
         end
         S_DIVI: begin
            cmd.op   = gcsl_pkg::OP_DIV_INIT;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = gcsl_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(gcsl_pkg::DIV_STEPS - 1)) begin
               state_in = S_EOS;
            end
         end
         S_EOS: begin
            cmd.op = gcsl_pkg::OP_EOS_UPD;
            if (axis_ff == gcsl_pkg::AXIS_Z) begin
               state_in = S_DONE;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = S_HF1;
            end
         end
         S_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule
`default_nettype wire

>>> sv/gcsl_dp.sv
`default_nettype none
module gcsl_dp (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire gcsl_pkg::cmd_type     cmd,
   input  wire gcsl_pkg::cfg_type     cfg,
   input  wire logic signed [17:0]    lf_tgt [3],
   input  wire logic signed [17:0]    hf_tgt [3],
   input  wire logic signed [17:0]    eos_tgt [3],
   input  wire logic        [19:0]    true_dt,
   input  wire logic        [19:0]    nominal_dt,
   input  wire logic        [19:0]    time_to_step,
   output gcsl_pkg::status_type       status,
   output logic signed [17:0]         lf_val [3],
   output logic signed [17:0]         hf_val [3],
   output logic signed [17:0]         eos_val [3]
);
   // Moves v by err, clamped to [-lo, hi], then saturates.
   function automatic logic signed [17:0] step_value(input logic signed [17:0] v,
                                                     input logic signed [18:0] err,
                                                     input logic [27:0] lo,
                                                     input logic [27:0] hi);
      logic signed [29:0] e;
      logic signed [29:0] l;
      logic signed [29:0] h;
      logic signed [29:0] c;
      logic signed [19:0] s;
      e = {{11{err[18]}}, err};
      l = -$signed({2'b00, lo});
      h = $signed({2'b00, hi});
      if (e < l) c = l;
      else if (e > h) c = h;
      else c = e;
      s = {{2{v[17]}}, v} + c[19:0];
      if (s > 20'sd131071) step_value = 18'sh1FFFF;
      else if (s < -20'sd131072) step_value = 18'sh20000;
      else step_value = s[17:0];
   endfunction

   logic signed [17:0] lf_tgt_ff [3];
   logic signed [17:0] hf_tgt_ff [3];
   logic signed [17:0] eos_tgt_ff [3];
   logic        [19:0] dt_ff, ndt_ff, tts_ff;
   logic signed [17:0] lf_ff [3];
   logic signed [17:0] hf_ff [3];
   logic signed [17:0] eos_ff [3];
   logic        [55:0] prod_ff, prod_in;
   logic        [23:0] lim1_ff;
   logic               neg_ff;
   logic        [19:0] rem_ff;
   logic        [17:0] dvd_ff;
   logic        [17:0] quo_ff;

   logic signed [17:0] lf_v, hf_v, eos_v;
   logic        [15:0] lf_slope, hf_slope;
   logic        [35:0] mul_a;
   logic        [19:0] mul_b;
   logic signed [18:0] hf_err, eos_err, eos_scaled;
   logic        [18:0] eos_mag;
   logic        [20:0] trial;
   logic        [27:0] lim2, lo_sel, hi_sel;

   assign lf_v  = lf_ff[cmd.axis];
   assign hf_v  = hf_ff[cmd.axis];
   assign eos_v = eos_ff[cmd.axis];
   assign status.scale = tts_ff > ndt_ff;

   always_comb begin
      unique case (cmd.axis)
         gcsl_pkg::AXIS_X: begin
            lf_slope = lf_v[17] ? cfg.lf_backward : cfg.lf_forward;
            hf_slope = cfg.hf_forward;
         end
         gcsl_pkg::AXIS_Y: begin
            lf_slope = cfg.lf_sideways;
            hf_slope = cfg.hf_sideways;
         end
         default: begin
            lf_slope = cfg.lf_turn;
            hf_slope = cfg.hf_turn;
         end
      endcase
   end

   assign hf_err  = 19'(hf_tgt_ff[cmd.axis]) - 19'(hf_v);
   assign eos_err = 19'(eos_tgt_ff[cmd.axis]) - 19'(eos_v);
   assign eos_mag = eos_err[18] ? 19'(-eos_err) : eos_err;
   assign lim2    = prod_ff[51:24];
   assign trial   = {rem_ff, dvd_ff[17]};
   assign eos_scaled = !status.scale ? eos_err
                     : (neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff}));
   assign lo_sel  = lf_v[17] ? 28'(lim1_ff) : lim2;
   assign hi_sel  = lf_v[17] ? lim2 : 28'(lim1_ff);

   always_comb begin
      mul_a = 36'(dt_ff);
      mul_b = 20'(lf_slope);
      priority case (cmd.op)
         gcsl_pkg::OP_LF_MUL2: begin
            mul_a = prod_ff[35:0];
            mul_b = 20'(cfg.decel_ratio);
         end
         gcsl_pkg::OP_HF_MUL: begin
            mul_b = 20'(hf_slope);
         end
         gcsl_pkg::OP_HF_UPD: begin
            mul_a = 36'(eos_mag[17:0]);
            mul_b = ndt_ff;
         end
         default: begin
         end
      endcase
      prod_in = 56'(mul_a) * 56'(mul_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            lf_ff[i]  <= '0;
            hf_ff[i]  <= '0;
            eos_ff[i] <= '0;
         end
      end else begin
         priority case (cmd.op)
            gcsl_pkg::OP_LF_UPD: begin
               lf_ff[cmd.axis] <= step_value(lf_v, 19'(lf_tgt_ff[cmd.axis]) - 19'(lf_v),
                                             lo_sel, hi_sel);
            end
            gcsl_pkg::OP_HF_UPD: begin
               hf_ff[cmd.axis] <= step_value(hf_v, hf_err, 28'(prod_ff[35:12]),
                                             28'(prod_ff[35:12]));
            end
            gcsl_pkg::OP_EOS_UPD: begin
               eos_ff[cmd.axis] <= step_value(eos_v, eos_scaled, 28'(lim1_ff),
                                              28'(lim1_ff));
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == gcsl_pkg::OP_LOAD) begin
         lf_tgt_ff  <= lf_tgt;
         hf_tgt_ff  <= hf_tgt;
         eos_tgt_ff <= eos_tgt;
         dt_ff      <= true_dt;
         ndt_ff     <= nominal_dt;
         tts_ff     <= time_to_step;
      end
      if (cmd.op == gcsl_pkg::OP_LF_MUL1 || cmd.op == gcsl_pkg::OP_LF_MUL2 ||
          cmd.op == gcsl_pkg::OP_HF_MUL || cmd.op == gcsl_pkg::OP_HF_UPD) begin
         prod_ff <= prod_in;
      end
      if (cmd.op == gcsl_pkg::OP_LF_MUL2 || cmd.op == gcsl_pkg::OP_HF_UPD) begin
         lim1_ff <= prod_ff[35:12];
      end
      if (cmd.op == gcsl_pkg::OP_HF_UPD) begin
         neg_ff <= eos_err[18];
      end
      if (cmd.op == gcsl_pkg::OP_DIV_INIT) begin
         rem_ff <= prod_ff[37:18];
         dvd_ff <= prod_ff[17:0];
         quo_ff <= '0;
      end
      if (cmd.op == gcsl_pkg::OP_DIV_STEP) begin
         dvd_ff <= {dvd_ff[16:0], 1'b0};
         if (trial >= 21'(tts_ff)) begin
            rem_ff <= 20'(trial - 21'(tts_ff));
            quo_ff <= {quo_ff[16:0], 1'b1};
         end else begin
            rem_ff <= trial[19:0];
            quo_ff <= {quo_ff[16:0], 1'b0};
         end
      end
   end

   assign lf_val  = lf_ff;
   assign hf_val  = hf_ff;
   assign eos_val = eos_ff;
endmodule
`default_nettype wire

>>> sv/gait_command_slope_limiter.sv
`default_nettype none
// Gait command slope limiter. Each request transaction carries nine velocity
// targets (low-frequency, high-frequency and end-of-step parts on the forward,
// sideways and turn axes) plus the true tick, the nominal tick and the time to
// the next step; the block moves nine running values toward those targets by
// at most tick times a per-axis slope and returns all nine in one response
// transaction. Low-frequency axes slow down at the slope scaled by the decel
// ratio, and the forward axis uses the backward slope while its value is
// negative. End-of-step errors are scaled by nominal tick over time to step
// when the time to step is longer than the nominal tick. One item is handled
// at a time: a new request is not taken until the last response is accepted.
// The single shared multiplier serves all the multiplies, and end-of-step
// scaling adds the one-bit-per-cycle divider; the response then waits for
// ready. The next request is taken in the cycle after the response is accepted.
// Seven slope registers and the decel ratio sit on APB byte addresses 0 to 28
// and all reset to 1.0; write them only while no transaction is in progress.
module gait_command_slope_limiter (
   input  wire logic         clock,
   input  wire logic         reset,
   gcsl_req_if.sink          req_chan,
   gcsl_rsp_if.source        rsp_chan,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [4:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic      [31:0]  csr_prdata,
   output logic              csr_pready
);
   gcsl_pkg::cfg_type    cfg_ff;
   gcsl_pkg::cmd_type    cmd;
   gcsl_pkg::status_type status;
   logic signed [17:0]   lf_tgt [3];
   logic signed [17:0]   hf_tgt [3];
   logic signed [17:0]   eos_tgt [3];
   logic signed [17:0]   lf_val [3];
   logic signed [17:0]   hf_val [3];
   logic signed [17:0]   eos_val [3];
   logic [2:0]           reg_idx;
   logic [15:0]          wdata;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wdata      = csr_pwdata[15:0];

   // Register file: a write lands on the access cycle of the transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= {gcsl_pkg::NUM_CFG{gcsl_pkg::CFG_RESET}};
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (reg_idx)
            gcsl_pkg::REG_LF_FORWARD:  cfg_ff.lf_forward  <= wdata;
            gcsl_pkg::REG_LF_BACKWARD: cfg_ff.lf_backward <= wdata;
            gcsl_pkg::REG_LF_SIDEWAYS: cfg_ff.lf_sideways <= wdata;
            gcsl_pkg::REG_LF_TURN:     cfg_ff.lf_turn     <= wdata;
            gcsl_pkg::REG_DECEL_RATIO: cfg_ff.decel_ratio <= wdata;
            gcsl_pkg::REG_HF_FORWARD:  cfg_ff.hf_forward  <= wdata;
            gcsl_pkg::REG_HF_SIDEWAYS: cfg_ff.hf_sideways <= wdata;
            gcsl_pkg::REG_HF_TURN:     cfg_ff.hf_turn     <= wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         gcsl_pkg::REG_LF_FORWARD:  csr_prdata = 32'(cfg_ff.lf_forward);
         gcsl_pkg::REG_LF_BACKWARD: csr_prdata = 32'(cfg_ff.lf_backward);
         gcsl_pkg::REG_LF_SIDEWAYS: csr_prdata = 32'(cfg_ff.lf_sideways);
         gcsl_pkg::REG_LF_TURN:     csr_prdata = 32'(cfg_ff.lf_turn);
         gcsl_pkg::REG_DECEL_RATIO: csr_prdata = 32'(cfg_ff.decel_ratio);
         gcsl_pkg::REG_HF_FORWARD:  csr_prdata = 32'(cfg_ff.hf_forward);
         gcsl_pkg::REG_HF_SIDEWAYS: csr_prdata = 32'(cfg_ff.hf_sideways);
         default:                   csr_prdata = 32'(cfg_ff.hf_turn);
      endcase
   end

   assign lf_tgt[0]  = req_chan.lf_target_x;
   assign lf_tgt[1]  = req_chan.lf_target_y;
   assign lf_tgt[2]  = req_chan.lf_target_z;
   assign hf_tgt[0]  = req_chan.hf_target_x;
   assign hf_tgt[1]  = req_chan.hf_target_y;
   assign hf_tgt[2]  = req_chan.hf_target_z;
   assign eos_tgt[0] = req_chan.eos_target_x;
   assign eos_tgt[1] = req_chan.eos_target_y;
   assign eos_tgt[2] = req_chan.eos_target_z;

   // The sequencer steps each axis through its multiplies and updates.
   gcsl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the running values, which also serve as the
   // response payload; they stay put until the next request updates them.
   gcsl_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .cfg          (cfg_ff),
      .lf_tgt       (lf_tgt),
      .hf_tgt       (hf_tgt),
      .eos_tgt      (eos_tgt),
      .true_dt      (req_chan.true_dt),
      .nominal_dt   (req_chan.nominal_dt),
      .time_to_step (req_chan.time_to_step),
      .status       (status),
      .lf_val       (lf_val),
      .hf_val       (hf_val),
      .eos_val      (eos_val)
   );

   assign rsp_chan.lf_x  = lf_val[0];
   assign rsp_chan.lf_y  = lf_val[1];
   assign rsp_chan.lf_z  = lf_val[2];
   assign rsp_chan.hf_x  = hf_val[0];
   assign rsp_chan.hf_y  = hf_val[1];
   assign rsp_chan.hf_z  = hf_val[2];
   assign rsp_chan.eos_x = eos_val[0];
   assign rsp_chan.eos_y = eos_val[1];
   assign rsp_chan.eos_z = eos_val[2];
endmodule
`default_nettype wire
